FILE: design/eng_pkg.sv
package eng_pkg;

   // Field widths
   localparam int SampleWidth = 16;
   localparam int EnvWidth    = 16;
   localparam int CoefWidth   = 15;
   localparam int Q15Shift    = 15;
   localparam int ProdWidth   = EnvWidth + CoefWidth;

   // Register file geometry: four 32-bit registers at byte addresses 0, 4, 8 and 12.
   localparam int AddrWidth = 4;
   localparam int DataWidth = 32;

   // Register indexes
   localparam logic [1:0] RegOpenThreshold = 2'd0;
   localparam logic [1:0] RegHoldSamples   = 2'd1;
   localparam logic [1:0] RegAttackCoef    = 2'd2;
   localparam logic [1:0] RegReleaseCoef   = 2'd3;

   // Register reset values
   localparam logic [EnvWidth-1:0]  RstOpenThreshold = 16'd1200;
   localparam logic [EnvWidth-1:0]  RstHoldSamples   = 16'd2400;
   localparam logic [CoefWidth-1:0] RstAttackCoef    = 15'd16384;
   localparam logic [CoefWidth-1:0] RstReleaseCoef   = 15'd655;

   // Configuration as seen by the gate datapath
   typedef struct packed {
      logic [EnvWidth-1:0]  open_threshold;
      logic [EnvWidth-1:0]  hold_samples;
      logic [CoefWidth-1:0] attack_coef;
      logic [CoefWidth-1:0] release_coef;
   } eng_cfg_type;

endpackage

FILE: design/eng_csr.sv
module eng_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [eng_pkg::AddrWidth-1:0] paddr,
   input  logic [eng_pkg::DataWidth-1:0] pwdata,
   output logic [eng_pkg::DataWidth-1:0] prdata,
   output logic                          pready,
   output eng_pkg::eng_cfg_type          cfg
);

   eng_pkg::eng_cfg_type cfg_ff;
   eng_pkg::eng_cfg_type cfg_in;
   logic [1:0]           reg_index;
   logic                 wr_en;

   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Write decode: bits above a register's width are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            eng_pkg::RegOpenThreshold: cfg_in.open_threshold = pwdata[eng_pkg::EnvWidth-1:0];
            eng_pkg::RegHoldSamples:   cfg_in.hold_samples   = pwdata[eng_pkg::EnvWidth-1:0];
            eng_pkg::RegAttackCoef:    cfg_in.attack_coef    = pwdata[eng_pkg::CoefWidth-1:0];
            eng_pkg::RegReleaseCoef:   cfg_in.release_coef   = pwdata[eng_pkg::CoefWidth-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_threshold <= eng_pkg::RstOpenThreshold;
         cfg_ff.hold_samples   <= eng_pkg::RstHoldSamples;
         cfg_ff.attack_coef    <= eng_pkg::RstAttackCoef;
         cfg_ff.release_coef   <= eng_pkg::RstReleaseCoef;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back of the addressed register, zero-extended.
   always_comb begin
      case (reg_index)
         eng_pkg::RegOpenThreshold: prdata = {16'd0, cfg_ff.open_threshold};
         eng_pkg::RegHoldSamples:   prdata = {16'd0, cfg_ff.hold_samples};
         eng_pkg::RegAttackCoef:    prdata = {17'd0, cfg_ff.attack_coef};
         eng_pkg::RegReleaseCoef:   prdata = {17'd0, cfg_ff.release_coef};
         default:                   prdata = '0;
      endcase
   end

endmodule

FILE: design/eng_gate.sv
module eng_gate (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  logic signed [eng_pkg::SampleWidth-1:0] sample,
   input  eng_pkg::eng_cfg_type                   cfg,
   output logic                                   gate_open
);

   logic [eng_pkg::EnvWidth-1:0]  env_ff;
   logic [eng_pkg::EnvWidth-1:0]  env_in;
   logic [eng_pkg::EnvWidth-1:0]  hold_ff;
   logic [eng_pkg::EnvWidth-1:0]  hold_in;
   logic                          gate_ff;
   logic                          gate_in;
   logic [eng_pkg::EnvWidth-1:0]  mag;
   logic                          rising;
   logic [eng_pkg::EnvWidth-1:0]  diff;
   logic [eng_pkg::CoefWidth-1:0] coef;
   logic [eng_pkg::ProdWidth-1:0] prod;
   logic [eng_pkg::EnvWidth-1:0]  delta;

   // Magnitude of the sample; full-scale negative gives 32768, which still fits 16 bits.
   assign mag = sample[eng_pkg::SampleWidth-1] ? (~sample + 1'b1) : sample;

   // Envelope follower: move towards the magnitude by a Q15 fraction of the gap.
   assign rising = mag > env_ff;
   assign diff   = rising ? (mag - env_ff) : (env_ff - mag);
   assign coef   = rising ? cfg.attack_coef : cfg.release_coef;
   assign prod   = {{eng_pkg::CoefWidth{1'b0}}, diff} * {{eng_pkg::EnvWidth{1'b0}}, coef};
   assign delta  = prod[eng_pkg::ProdWidth-1:eng_pkg::Q15Shift];
   assign env_in = rising ? (env_ff + delta) : (env_ff - delta);

   // Gate with hold: open and reload at threshold, else count down, then close.
   always_comb begin
      hold_in = hold_ff;
      gate_in = gate_ff;
      if (env_in >= cfg.open_threshold) begin
         gate_in = 1'b1;
         hold_in = cfg.hold_samples;
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - 1'b1;
      end else begin
         gate_in = 1'b0;
      end
   end

   assign gate_open = gate_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff  <= '0;
         hold_ff <= '0;
         gate_ff <= 1'b1;
      end else if (step) begin
         env_ff  <= env_in;
         hold_ff <= hold_in;
         gate_ff <= gate_in;
      end
   end

endmodule

FILE: design/envelope_noise_gate.sv
// Envelope-driven noise gate with hold time.
// An accepted transaction moves from the input register to the result register.
// Throughput: one transaction per cycle unless stalled; envelope and hold loop unpipelined.
// Reset (synchronous): envelope and hold counter cleared, gate open, registers at defaults,
// both pipeline stages empty.
module envelope_noise_gate (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [eng_pkg::SampleWidth-1:0] req_sample_in,
   input  logic                                   req_last_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [eng_pkg::SampleWidth-1:0] rsp_sample_out,
   output logic                                   rsp_gate_state,
   output logic                                   rsp_last_out,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [eng_pkg::AddrWidth-1:0]          paddr,
   input  logic [eng_pkg::DataWidth-1:0]          pwdata,
   output logic [eng_pkg::DataWidth-1:0]          prdata,
   output logic                                   pready
);

   eng_pkg::eng_cfg_type cfg;

   logic                                   in_valid_ff;
   logic                                   in_valid_in;
   logic signed [eng_pkg::SampleWidth-1:0] in_sample_ff;
   logic                                   in_last_ff;
   logic                                   out_valid_ff;
   logic                                   out_valid_in;
   logic signed [eng_pkg::SampleWidth-1:0] out_sample_ff;
   logic                                   out_gate_ff;
   logic                                   out_last_ff;
   logic                                   advance;
   logic                                   req_take;
   logic                                   gate_open;

   eng_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The input stage moves on when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   eng_gate u_gate (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sample    (in_sample_ff),
      .cfg       (cfg),
      .gate_open (gate_open)
   );

   // Stage occupancy.
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register for the accepted transaction.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample_in;
         in_last_ff   <= req_last_in;
      end
   end

   // Result register; the sample is muted while the gate is closed.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= gate_open ? in_sample_ff : '0;
         out_gate_ff   <= gate_open;
         out_last_ff   <= in_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_gate_state = out_gate_ff;
   assign rsp_last_out   = out_last_ff;

endmodule

FILE: verif/envelope_noise_gate_tb.sv
module envelope_noise_gate_tb;

   // One expected output transaction of the gate.
   typedef struct {
      logic signed [eng_pkg::SampleWidth-1:0] pcm;
      logic                                   gate;
      logic                                   last;
   } gate_result_type;

   // Tracks the envelope, hold counter and gate, and queues the outputs they imply.
   class gate_tracker_type;
      logic [eng_pkg::EnvWidth-1:0]  open_threshold = eng_pkg::RstOpenThreshold;
      logic [eng_pkg::EnvWidth-1:0]  hold_samples   = eng_pkg::RstHoldSamples;
      logic [eng_pkg::CoefWidth-1:0] attack_coef    = eng_pkg::RstAttackCoef;
      logic [eng_pkg::CoefWidth-1:0] release_coef   = eng_pkg::RstReleaseCoef;
      logic [eng_pkg::EnvWidth-1:0]  envelope       = '0;
      logic [eng_pkg::EnvWidth-1:0]  hold_left      = '0;
      logic                          gate_open      = 1'b1;
      gate_result_type               expected_outputs[$];
      int                            failures       = 0;

      // Mirror a register write; bits above the register width are dropped.
      function void set_reg(logic [1:0] index, logic [eng_pkg::DataWidth-1:0] value);
         case (index)
            eng_pkg::RegOpenThreshold: open_threshold = value[eng_pkg::EnvWidth-1:0];
            eng_pkg::RegHoldSamples:   hold_samples   = value[eng_pkg::EnvWidth-1:0];
            eng_pkg::RegAttackCoef:    attack_coef    = value[eng_pkg::CoefWidth-1:0];
            eng_pkg::RegReleaseCoef:   release_coef   = value[eng_pkg::CoefWidth-1:0];
            default: ;
         endcase
      endfunction

      // Advance the envelope and gate for one accepted input transaction.
      function void note_sample(logic signed [eng_pkg::SampleWidth-1:0] pcm, logic last);
         logic [31:0]     mag;
         logic [31:0]     env;
         logic [31:0]     change;
         gate_result_type res;
         mag = pcm[eng_pkg::SampleWidth-1] ? 32'h10000 - {16'b0, pcm} : {16'b0, pcm};
         env = {16'b0, envelope};
         if (mag > env) begin
            change   = ((mag - env) * {17'b0, attack_coef}) >> eng_pkg::Q15Shift;
            envelope = envelope + change[eng_pkg::EnvWidth-1:0];
         end else begin
            change   = ((env - mag) * {17'b0, release_coef}) >> eng_pkg::Q15Shift;
            envelope = envelope - change[eng_pkg::EnvWidth-1:0];
         end
         // The gate opens at the threshold, else the hold runs down before it closes.
         if (envelope >= open_threshold) begin
            gate_open = 1'b1;
            hold_left = hold_samples;
         end else if (hold_left != 0) begin
            hold_left = hold_left - 1'b1;
         end else begin
            gate_open = 1'b0;
         end
         res.pcm  = gate_open ? pcm : '0;
         res.gate = gate_open;
         res.last = last;
         expected_outputs.push_back(res);
      endfunction

      // Compare one output transaction with the oldest expectation.
      function void check_output(logic signed [eng_pkg::SampleWidth-1:0] pcm, logic gate,
                                 logic last);
         gate_result_type want;
         if (expected_outputs.size() == 0) begin
            $display("%0t: output with nothing expected: sample_out %0d gate_state %0b",
                     $time, pcm, gate);
            failures++;
            return;
         end
         want = expected_outputs.pop_front();
         if (pcm !== want.pcm) begin
            $display("%0t: sample_out expected %0d, got %0d", $time, want.pcm, pcm);
            failures++;
         end
         if (gate !== want.gate) begin
            $display("%0t: gate_state expected %0b, got %0b", $time, want.gate, gate);
            failures++;
         end
         if (last !== want.last) begin
            $display("%0t: last_out expected %0b, got %0b", $time, want.last, last);
            failures++;
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

   logic                                   clock         = 1'b0;
   logic                                   reset         = 1'b1;
   logic                                   req_valid     = 1'b0;
   logic                                   req_ready;
   logic signed [eng_pkg::SampleWidth-1:0] req_sample_in = '0;
   logic                                   req_last_in   = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready     = 1'b0;
   logic signed [eng_pkg::SampleWidth-1:0] rsp_sample_out;
   logic                                   rsp_gate_state;
   logic                                   rsp_last_out;
   logic                                   psel          = 1'b0;
   logic                                   penable       = 1'b0;
   logic                                   pwrite        = 1'b0;
   logic [eng_pkg::AddrWidth-1:0]          paddr         = '0;
   logic [eng_pkg::DataWidth-1:0]          pwdata        = '0;
   logic [eng_pkg::DataWidth-1:0]          prdata;
   logic                                   pready;

   int               send_gap_max  = 0;
   int               recv_gap_max  = 0;
   logic             stall_request = 1'b0;
   gate_tracker_type tracker;

   envelope_noise_gate uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_sample_in, .req_last_in,
      .rsp_valid, .rsp_ready, .rsp_sample_out, .rsp_gate_state, .rsp_last_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one sample after a random gap and wait until the transaction is accepted.
   task automatic send_sample(input logic signed [eng_pkg::SampleWidth-1:0] pcm,
                              input logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= pcm;
      req_last_in   <= last;
      do @(posedge clock); while (!req_ready);
      tracker.note_sample(pcm, last);
   endtask

   // Write one register through a setup phase and an access phase.
   task automatic write_reg(input logic [1:0] index,
                            input logic [eng_pkg::DataWidth-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.set_reg(index, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Stop offering input and let every expected output drain before going on.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly extremes and small values, with junk in bits 17 and up, above every register.
   function automatic logic [eng_pkg::DataWidth-1:0] random_setting(int unsigned top,
                                                                    int unsigned typical);
      logic [eng_pkg::DataWidth-1:0] v;
      case ($urandom_range(0, 4))
         0:       v = '0;
         1:       v = top;
         2:       v = $urandom_range(0, top);
         default: v = $urandom_range(0, typical);
      endcase
      return v | ({$urandom} << 17);
   endfunction

   // Bursts of loud and quiet audio so that the gate opens, holds and closes.
   task automatic run_random_phase(input int count);
      int                                     sent;
      int                                     run;
      int                                     amp;
      int                                     mag;
      logic signed [eng_pkg::SampleWidth-1:0] pcm;
      sent = 0;
      while (sent < count) begin
         run = $urandom_range(1, 30);
         amp = $urandom_range(0, 1) ? $urandom_range(1000, 32768) : $urandom_range(0, 300);
         for (int k = 0; k < run && sent < count; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               pcm = 16'($urandom);
            end else begin
               mag = $urandom_range(0, amp);
               pcm = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag > 32767 ? 32767 : mag);
            end
            send_sample(pcm, k == run - 1 || $urandom_range(0, 15) == 0);
            sent++;
         end
      end
   endtask

   // Output side: random hold-offs, and one long one on request to back up the input.
   initial begin
      int hold;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         hold = $urandom_range(0, recv_gap_max);
         if (stall_request) begin
            hold = 80;
            stall_request <= 1'b0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_output(rsp_sample_out, rsp_gate_state, rsp_last_out);
      end
   end

   initial begin
      tracker = new;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: quiet samples close the gate at once, since the hold starts at zero; loud ones reopen it.
      send_gap_max = 2;
      recv_gap_max = 2;
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b1);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd32767, 1'b1);
      send_sample(-16'sd32767, 1'b0);
      settle();

      // Threshold zero keeps the gate open; the fastest attack drives full-scale negatives.
      write_reg(eng_pkg::RegHoldSamples, 32'h0000_0000);
      write_reg(eng_pkg::RegOpenThreshold, 32'h0000_0000);
      write_reg(eng_pkg::RegAttackCoef, 32'hffff_ffff);
      write_reg(eng_pkg::RegReleaseCoef, 32'h0000_7fff);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sd32767, 1'b0);
      settle();

      // A threshold beyond the envelope range with no hold shuts the gate on the next sample.
      write_reg(eng_pkg::RegOpenThreshold, 32'h0000_8000);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd0, 1'b0);
      settle();

      // A short hold counts down before the gate closes, then a loud sample reopens it.
      write_reg(eng_pkg::RegOpenThreshold, 32'h0000_4e20);
      write_reg(eng_pkg::RegHoldSamples, 32'habcd_0003);
      write_reg(eng_pkg::RegReleaseCoef, 32'h0000_4000);
      send_sample(16'sd32767, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd5, 1'b1);
      send_sample(16'sh8000, 1'b0);
      settle();

      // Frozen envelope with an unreachable threshold and the longest hold.
      write_reg(eng_pkg::RegOpenThreshold, 32'h0001_ffff);
      write_reg(eng_pkg::RegHoldSamples, 32'h0000_ffff);
      write_reg(eng_pkg::RegAttackCoef, 32'h0000_0000);
      write_reg(eng_pkg::RegReleaseCoef, 32'h0000_0000);
      send_sample(16'sd12345, 1'b1);
      send_sample(-16'sd21846, 1'b0);
      settle();

      // Random settings per phase, with phases of back-to-back transactions on each side.
      for (int p = 0; p < 10; p++) begin
         write_reg(eng_pkg::RegOpenThreshold, random_setting(65535, 6000));
         write_reg(eng_pkg::RegHoldSamples, random_setting(65535, 40));
         write_reg(eng_pkg::RegAttackCoef, random_setting(32767, 32767));
         write_reg(eng_pkg::RegReleaseCoef, random_setting(32767, 4000));
         send_gap_max = (p % 3 == 1) ? 0 : 6;
         recv_gap_max = (p % 4 == 2) ? 0 : 6;
         if (p == 4)
            stall_request <= 1'b1;
         run_random_phase(113);
         settle();
      end

      if (tracker.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
